### hdl/srwt_pkg.sv
// Shared types, constants and helper functions for the slow-read window tracker.
// Used by every module of the block except srwt_ram; depends on nothing else.
package srwt_pkg;

  // Flow table geometry
  localparam int FLOW_ENTRIES = 64;
  localparam int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SERVER_IP   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_PORT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_THR     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 4'd3;

  localparam logic [31:0] RST_SERVER_IP   = 32'h7F00_0001;
  localparam logic [15:0] RST_SERVER_PORT = 16'd80;
  localparam logic [29:0] RST_WIN_THR     = 30'd65000;
  localparam logic [7:0]  RST_COUNT_LIMIT = 8'd5;

  // TCP flag bit positions
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

  localparam logic [3:0] MAX_SCALE = 4'd14;

  typedef enum logic [2:0] {
    ACT_IGNORE = 3'd0,
    ACT_TRACK  = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_DETECT = 3'd3,
    ACT_FULL   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  // One flow table entry; its valid bit lives in flip-flops beside the memory
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [3:0]  ws;
    logic        fin_sent;
    logic        fin_rec;
    logic [7:0]  count;
  } flow_t;

  localparam int ENTRY_W = $bits(flow_t);

  typedef struct packed {
    logic [31:0] src_ip;
    logic [15:0] src_tcp_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;
    logic [15:0] window;
    logic [7:0]  window_scale;
  } pkt_t;

  typedef struct packed {
    logic [31:0] server_ip;
    logic [15:0] server_port;
    logic [29:0] window_threshold;
    logic [7:0]  count_limit;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [7:0]  small_count;
    logic [31:0] detect_number;
  } result_t;

  // Sequencer status towards the top level
  typedef struct packed {
    logic busy;
    logic res_load;
  } ctrl_stat_t;

  // Small-window count, saturating at its maximum.
  function automatic logic [7:0] sat_inc(input logic [7:0] cnt);
    return (cnt != 8'hFF) ? cnt + 8'd1 : cnt;
  endfunction

  // Window scale option, clamped to the largest legal shift.
  function automatic logic [3:0] clamp_scale(input logic [7:0] ws);
    return (ws > {4'd0, MAX_SCALE}) ? MAX_SCALE : ws[3:0];
  endfunction

endpackage

### hdl/srwt_ram.sv
// Generic single-write, single-read memory with registered read data.
// Holds the flow table payload; no package dependency.
module srwt_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 62,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/srwt_match.sv
// Shared compare unit: checks one table entry against the lookup key.
// Depends on srwt_pkg for the entry type.
module srwt_match (
  input  logic [31:0]     key_ip,
  input  logic [15:0]     key_port,
  input  srwt_pkg::flow_t entry,
  input  logic            entry_valid,
  output logic            hit,
  output logic            free
);
  import srwt_pkg::*;

  // A live entry with the same client address and port is a hit.
  assign hit  = entry_valid && (entry.ip == key_ip) && (entry.port == key_port);
  // An empty slot is a candidate for a new connection.
  assign free = !entry_valid;

endmodule

### hdl/srwt_ctrl.sv
// Sequencer of the tracker: scans the flow table one entry a cycle, then applies
// the packet rules. Depends on srwt_pkg, srwt_ram and srwt_match.
module srwt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  srwt_pkg::pkt_t      pkt,
  input  srwt_pkg::cfg_t      cfg,
  input  logic                out_free,
  output srwt_pkg::ctrl_stat_t stat,
  output srwt_pkg::result_t   res
);
  import srwt_pkg::*;

  state_t            state_r, state_nxt;
  pkt_t              pkt_r;
  logic              is_srv_r;
  logic [31:0]       key_ip_r;
  logic [15:0]       key_port_r;
  logic [CNT_W-1:0]  scan_cnt_r;
  logic              cmp_pend_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  flow_t             hit_ent_r;
  logic              free_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [FLOW_ENTRIES-1:0] valid_r;
  logic [31:0]       det_r;

  logic              accept;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic              wr_en;
  logic              m_hit;
  logic              m_free;
  logic              scan_hit;
  logic              scan_free;

  // Decision results
  action_t           act;
  flow_t             new_ent;
  logic [IDX_W-1:0]  upd_idx;
  logic              upd_wr;
  logic              upd_set;
  logic              upd_clr;
  logic              det;
  logic [7:0]        cnt_out;
  logic [31:0]       det_nxt;

  assign accept = (state_r == ST_IDLE) && in_valid;

  // Flow table payload memory
  srwt_ram #(
    .DEPTH (FLOW_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (upd_idx),
    .wr_data (new_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Compare unit, reused for every entry of the scan
  srwt_match u_match (
    .key_ip      (key_ip_r),
    .key_port    (key_port_r),
    .entry       (flow_t'(rd_data)),
    .entry_valid (valid_r[cmp_idx_r]),
    .hit         (m_hit),
    .free        (m_free)
  );

  assign scan_hit  = (state_r == ST_SCAN) && cmp_pend_r && m_hit && !hit_r;
  assign scan_free = (state_r == ST_SCAN) && cmp_pend_r && m_free && !free_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((scan_cnt_r == CNT_W'(FLOW_ENTRIES)) && cmp_pend_r) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    rd_en         = (state_r == ST_SCAN) && (scan_cnt_r < CNT_W'(FLOW_ENTRIES));
    rd_addr       = scan_cnt_r[IDX_W-1:0];
    stat.busy     = (state_r != ST_IDLE);
    stat.res_load = (state_r == ST_APPLY) && out_free;
    wr_en         = stat.res_load && upd_wr;
  end

  // Packet rules, worked out from the entry found by the scan
  always_comb begin
    logic fin;
    logic syn;
    logic rst;
    logic ack_only;
    logic [30:0] scaled;
    fin      = pkt_r.tcp_flags[FLAG_FIN];
    syn      = pkt_r.tcp_flags[FLAG_SYN];
    rst      = pkt_r.tcp_flags[FLAG_RST];
    ack_only = pkt_r.tcp_flags[FLAG_ACK] && !fin;
    scaled   = {15'd0, pkt_r.window} << hit_ent_r.ws;

    act     = ACT_IGNORE;
    new_ent = hit_ent_r;
    upd_idx = hit_idx_r;
    upd_wr  = 1'b0;
    upd_set = 1'b0;
    upd_clr = 1'b0;
    det     = 1'b0;
    cnt_out = 8'd0;

    if (is_srv_r) begin
      // Server side: FIN marks, ACK after own FIN or RST closes
      if (hit_r) begin
        cnt_out = hit_ent_r.count;
        if (fin) begin
          if (!hit_ent_r.fin_rec) begin
            new_ent.fin_sent = 1'b1;
            upd_wr           = 1'b1;
            act              = ACT_TRACK;
          end
        end else if (ack_only) begin
          if (hit_ent_r.fin_sent) begin
            upd_clr = 1'b1;
            act     = ACT_REMOVE;
          end
        end else if (rst) begin
          upd_clr = 1'b1;
          act     = ACT_REMOVE;
        end
      end
    end else if (syn) begin
      // Client SYN: create or refresh the entry, or report a full table
      if (!hit_r && !free_r) begin
        act = ACT_FULL;
      end else begin
        if (!hit_r) begin
          upd_idx          = free_idx_r;
          new_ent.ip       = key_ip_r;
          new_ent.port     = key_port_r;
          new_ent.fin_sent = 1'b0;
          new_ent.fin_rec  = 1'b0;
          new_ent.count    = 8'd0;
        end
        new_ent.ws = clamp_scale(pkt_r.window_scale);
        upd_wr     = 1'b1;
        upd_set    = 1'b1;
        act        = ACT_TRACK;
        if ({14'd0, pkt_r.window} < cfg.window_threshold) begin
          new_ent.count = sat_inc(new_ent.count);
          if (new_ent.count >= cfg.count_limit) begin
            det     = 1'b1;
            upd_clr = 1'b1;
            act     = ACT_DETECT;
          end
        end
        cnt_out = new_ent.count;
      end
    end else if (hit_r) begin
      // Client data or teardown on a known connection
      if (rst) begin
        upd_clr = 1'b1;
        act     = ACT_REMOVE;
      end else begin
        if (scaled < {1'b0, cfg.window_threshold}) begin
          new_ent.count = sat_inc(hit_ent_r.count);
          upd_wr        = 1'b1;
          act           = ACT_TRACK;
          if (new_ent.count >= cfg.count_limit) begin
            det     = 1'b1;
            upd_clr = 1'b1;
            act     = ACT_DETECT;
          end
        end
        if (!det) begin
          if (ack_only) begin
            if (hit_ent_r.fin_rec) begin
              upd_clr = 1'b1;
              act     = ACT_REMOVE;
            end
          end else if (fin && !hit_ent_r.fin_sent) begin
            new_ent.fin_rec = 1'b1;
            upd_wr          = 1'b1;
            act             = ACT_TRACK;
          end
        end
      end
      cnt_out = new_ent.count;
    end

    det_nxt = (det && (det_r != 32'hFFFF_FFFF)) ? det_r + 32'd1 : det_r;
  end

  // Result word handed to the output register
  always_comb begin
    res.action        = act;
    res.client_ip     = key_ip_r;
    res.client_port   = key_port_r;
    res.small_count   = cnt_out;
    res.detect_number = det_nxt;
  end

  // Control state: sequencer, scan flags, valid bits and detection counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_cnt_r <= '0;
      cmp_pend_r <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      valid_r    <= '0;
      det_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        scan_cnt_r <= '0;
        cmp_pend_r <= 1'b0;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        cmp_pend_r <= rd_en;
        if (rd_en) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        if (scan_hit) begin
          hit_r <= 1'b1;
        end
        if (scan_free) begin
          free_r <= 1'b1;
        end
      end
      if (stat.res_load) begin
        if (upd_clr) begin
          valid_r[upd_idx] <= 1'b0;
        end else if (upd_set) begin
          valid_r[upd_idx] <= 1'b1;
        end
        det_r <= det_nxt;
      end
    end
  end

  // Payload: captured packet, lookup key and scan results
  always_ff @(posedge clk) begin
    if (accept) begin
      pkt_r    <= pkt;
      is_srv_r <= (pkt.src_ip == cfg.server_ip) && (pkt.src_tcp_port == cfg.server_port);
      if ((pkt.src_ip == cfg.server_ip) && (pkt.src_tcp_port == cfg.server_port)) begin
        key_ip_r   <= pkt.dst_ip;
        key_port_r <= pkt.dst_port;
      end else begin
        key_ip_r   <= pkt.src_ip;
        key_port_r <= pkt.src_tcp_port;
      end
    end
    if (rd_en) begin
      cmp_idx_r <= rd_addr;
    end
    if (scan_hit) begin
      hit_idx_r <= cmp_idx_r;
      hit_ent_r <= flow_t'(rd_data);
    end
    if (scan_free) begin
      free_idx_r <= cmp_idx_r;
    end
  end

endmodule

### hdl/slow_read_window_tracker.sv
// Top level of the slow-read window tracker: configuration registers, output
// register and the sequencer. Depends on srwt_pkg and srwt_ctrl.
//
//   Channel  Direction  Handshake            Carries
//   in_      input      in_valid / in_stall  one word of parsed TCP header fields
//   out_     output     out_valid/ out_stall one result word per input word
//   cfg_     input      cfg_valid/ cfg_ready register index and write data
//
// A word's result is loaded into the output register after the flow table has
// been scanned through its single read port, one entry a cycle, and the packet
// rules applied; no new word is accepted until then. in_stall is high for the
// whole of that time; a result waiting in the output register holds the next
// finished word in the sequencer until it is taken.
// Reset clears the valid bits of all entries at once; no clearing pass follows.
// cfg_ready is always high; writes to an unknown index are ignored.
module slow_read_window_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_src_ip,
  input  logic [15:0]                    in_src_tcp_port,
  input  logic [31:0]                    in_dst_ip,
  input  logic [15:0]                    in_dst_port,
  input  logic [7:0]                     in_tcp_flags,
  input  logic [15:0]                    in_window,
  input  logic [7:0]                     in_window_scale,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_action,
  output logic [31:0]                    out_client_ip,
  output logic [15:0]                    out_client_port,
  output logic [7:0]                     out_small_count,
  output logic [31:0]                    out_detect_number,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srwt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srwt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srwt_pkg::*;

  cfg_t       cfg_r;
  pkt_t       pkt;
  ctrl_stat_t stat;
  result_t    res;
  result_t    out_r;
  logic       out_valid_r;
  logic       out_free;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.server_ip        <= RST_SERVER_IP;
      cfg_r.server_port      <= RST_SERVER_PORT;
      cfg_r.window_threshold <= RST_WIN_THR;
      cfg_r.count_limit      <= RST_COUNT_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SERVER_IP:   cfg_r.server_ip        <= cfg_data[31:0];
        REG_SERVER_PORT: cfg_r.server_port      <= cfg_data[15:0];
        REG_WIN_THR:     cfg_r.window_threshold <= cfg_data[29:0];
        REG_COUNT_LIMIT: cfg_r.count_limit      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input word gathered into one struct
  always_comb begin
    pkt.src_ip       = in_src_ip;
    pkt.src_tcp_port = in_src_tcp_port;
    pkt.dst_ip       = in_dst_ip;
    pkt.dst_port     = in_dst_port;
    pkt.tcp_flags    = in_tcp_flags;
    pkt.window       = in_window;
    pkt.window_scale = in_window_scale;
  end

  assign out_free = !out_valid_r || !out_stall;

  srwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .pkt      (pkt),
    .cfg      (cfg_r),
    .out_free (out_free),
    .stat     (stat),
    .res      (res)
  );

  assign in_stall = stat.busy;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_load) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_r.action;
  assign out_client_ip     = out_r.client_ip;
  assign out_client_port   = out_r.client_port;
  assign out_small_count   = out_r.small_count;
  assign out_detect_number = out_r.detect_number;

endmodule

### hdl/srwt_checker.sv
// Port-level checks of the slow-read window tracker's result channel, and the
// bind that attaches them to the top level. Depends on srwt_pkg.
module srwt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_action,
  input logic [31:0] out_client_ip,
  input logic [15:0] out_client_port,
  input logic [7:0]  out_small_count,
  input logic [31:0] out_detect_number
);
  import srwt_pkg::*;

  logic [31:0] last_det_r;

  // Detection total of the last word taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_det_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_det_r <= out_detect_number;
    end
  end

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_client_ip) && $stable(out_client_port) &&
      $stable(out_small_count) && $stable(out_detect_number))
    else $error("result word changed while stalled");

  // A detection advances the total by one, unless it has saturated.
  a_det_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_DETECT) |->
      (out_detect_number == last_det_r + 32'd1) ||
      ((last_det_r == 32'hFFFF_FFFF) && (out_detect_number == 32'hFFFF_FFFF)))
    else $error("detection total did not step on a detection");

  // Any other word leaves the total as it was.
  a_det_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != ACT_DETECT) |-> out_detect_number == last_det_r)
    else $error("detection total moved without a detection");

  // The total never goes down.
  a_det_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_detect_number >= last_det_r)
    else $error("detection total decreased");

  // A full table means no entry, hence no count.
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_FULL) |-> out_small_count == 8'd0)
    else $error("table-full word carries a count");

endmodule

bind slow_read_window_tracker srwt_checker u_srwt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_action        (out_action),
  .out_client_ip     (out_client_ip),
  .out_client_port   (out_client_port),
  .out_small_count   (out_small_count),
  .out_detect_number (out_detect_number)
);
